FILE: sv/tlvts_pkg.sv
// ----------------------------------------------------------------------------
// tlvts_pkg
// Types, constants and helpers shared by the tag-length-value search decoder.
// ----------------------------------------------------------------------------
package tlvts_pkg;

	localparam int unsigned MAX_BUFFER_BYTES_DEF = 65536;
	localparam int unsigned HDR_LEN              = 5;
	localparam int unsigned MAX_VALUE_BYTES      = 8;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_NOT_SUPPORTED = 2'd1,
		ST_NOT_FOUND     = 2'd2,
		ST_OUT_OF_RANGE  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] value;
		logic [15:0] value_length;
		logic [16:0] end_offset;
	} out_item_t;

	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h00;
			3'd1: b = 8'h00;
			3'd2: b = 8'h00;
			3'd3: b = 8'h01;
			3'd4: b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: sv/tlvts_parser.sv
// ----------------------------------------------------------------------------
// tlvts_parser
// Byte-wise tuple parser: header check, tag match, unsigned value decode.
// ----------------------------------------------------------------------------
module tlvts_parser #(
	parameter int unsigned MAX_BUFFER_BYTES = tlvts_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  tlvts_pkg::in_item_t  item,
	input  logic [15:0]          wanted_tag,
	output tlvts_pkg::out_item_t res
);

	localparam int unsigned OFFW = $clog2(MAX_BUFFER_BYTES + 1);

	typedef enum logic [5:0] {
		PH_TAG_HI = 6'b000001,
		PH_TAG_LO = 6'b000010,
		PH_LEN_HI = 6'b000100,
		PH_LEN_LO = 6'b001000,
		PH_VALUE  = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	phase_t      phase_q,   phase_n;
	logic [OFFW-1:0] off_q, off_n;
	logic        hok_q,     hok_n;
	logic [15:0] tag_q,     tag_n;
	logic [15:0] len_q,     len_n;
	logic [15:0] left_q,    left_n;
	logic [63:0] acc_q,     acc_n;
	logic [3:0]  sig_q,     sig_n;
	logic        collect_q, collect_n;
	logic        found_q,   found_n;
	logic        range_q,   range_n;
	logic [OFFW-1:0] mend_q, mend_n;
	logic [15:0] len_v;
	logic        first_v;
	logic [OFFW+16:0] mend_ext;

	always_comb begin
		phase_n   = phase_q;
		off_n     = off_q;
		hok_n     = hok_q;
		tag_n     = tag_q;
		len_n     = len_q;
		left_n    = left_q;
		acc_n     = acc_q;
		sig_n     = sig_q;
		collect_n = collect_q;
		found_n   = found_q;
		range_n   = range_q;
		mend_n    = mend_q;
		len_v     = len_q | {8'h00, item.data_byte};
		first_v   = (left_q == len_q);
		if (off_q < OFFW'(MAX_BUFFER_BYTES)) begin
			if (off_q < OFFW'(tlvts_pkg::HDR_LEN)
					&& item.data_byte != tlvts_pkg::hdr_byte(off_q[2:0])) begin
				hok_n = 1'b0;
			end
			case (phase_q)
				PH_TAG_HI: begin
					tag_n   = {item.data_byte, 8'h00};
					phase_n = PH_TAG_LO;
				end
				PH_TAG_LO: begin
					tag_n   = tag_q | {8'h00, item.data_byte};
					phase_n = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_n   = {item.data_byte, 8'h00};
					phase_n = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_n = len_v;
					if (len_v == 16'h0000) begin
						if (tag_q == wanted_tag) begin
							collect_n = 1'b0;
							found_n   = 1'b1;
							range_n   = 1'b1;
							mend_n    = off_q + OFFW'(1);
							phase_n   = PH_DONE;
						end else begin
							phase_n = PH_TAG_HI;
						end
					end else begin
						left_n    = len_v;
						acc_n     = 64'h0;
						sig_n     = 4'd0;
						collect_n = (tag_q == wanted_tag);
						found_n   = 1'b0;
						range_n   = 1'b0;
						phase_n   = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (collect_q) begin
						if (first_v && item.data_byte[7]) begin
							range_n = 1'b1;
						end
						if (!(first_v && item.data_byte == 8'h00)) begin
							if (sig_q < 4'd9) begin
								sig_n = sig_q + 4'd1;
							end
							acc_n = {acc_q[55:0], item.data_byte};
						end
					end
					left_n = left_q - 16'd1;
					if (left_n == 16'h0000) begin
						if (collect_q) begin
							if (sig_n > 4'(tlvts_pkg::MAX_VALUE_BYTES)) begin
								range_n = 1'b1;
							end
							collect_n = 1'b0;
							found_n   = 1'b1;
							mend_n    = off_q + OFFW'(1);
							phase_n   = PH_DONE;
						end else begin
							phase_n = PH_TAG_HI;
						end
					end
				end
				default: begin
				end
			endcase
			off_n = off_q + OFFW'(1);
		end
	end

	always_comb begin
		mend_ext = {17'h00000, mend_n};
		res      = '0;
		if (!hok_n || off_n < OFFW'(tlvts_pkg::HDR_LEN)) begin
			res.status = tlvts_pkg::ST_NOT_SUPPORTED;
		end else if (found_n) begin
			res.status       = range_n ? tlvts_pkg::ST_OUT_OF_RANGE : tlvts_pkg::ST_OK;
			res.value        = range_n ? 64'h0 : acc_n;
			res.value_length = len_n;
			res.end_offset   = mend_ext[16:0];
		end else begin
			res.status = tlvts_pkg::ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TAG_HI;
			off_q     <= '0;
			hok_q     <= 1'b1;
			tag_q     <= '0;
			len_q     <= '0;
			left_q    <= '0;
			acc_q     <= '0;
			sig_q     <= '0;
			collect_q <= 1'b0;
			found_q   <= 1'b0;
			range_q   <= 1'b0;
			mend_q    <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q   <= PH_TAG_HI;
				off_q     <= '0;
				hok_q     <= 1'b1;
				tag_q     <= '0;
				len_q     <= '0;
				left_q    <= '0;
				acc_q     <= '0;
				sig_q     <= '0;
				collect_q <= 1'b0;
				found_q   <= 1'b0;
				range_q   <= 1'b0;
				mend_q    <= '0;
			end else begin
				phase_q   <= phase_n;
				off_q     <= off_n;
				hok_q     <= hok_n;
				tag_q     <= tag_n;
				len_q     <= len_n;
				left_q    <= left_n;
				acc_q     <= acc_n;
				sig_q     <= sig_n;
				collect_q <= collect_n;
				found_q   <= found_n;
				range_q   <= range_n;
				mend_q    <= mend_n;
			end
		end
	end

endmodule

FILE: sv/tlv_tag_search_uint_decoder.sv
// Order: a byte accepted into item_s1 is parsed at the edge on which it steps the
// parser; the result item of a last byte is registered at that same edge.
// Throughput: one byte per cycle; a last byte waits only while the result
// register still holds an item that has not been taken.
// Reset: arst_n clears the parser to the tag-high phase, wanted_tag to zero and
// both valid flags.
// ----------------------------------------------------------------------------
// tlv_tag_search_uint_decoder
// Searches a tag-length-value buffer for one tag and decodes its value.
// ----------------------------------------------------------------------------
module tlv_tag_search_uint_decoder #(
	parameter int unsigned MAX_BUFFER_BYTES = tlvts_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tlvts_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tlvts_pkg::out_item_t out_item,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data
);

	logic                 valid_s1;
	tlvts_pkg::in_item_t  item_s1;
	logic                 out_valid_q;
	tlvts_pkg::out_item_t out_item_q;
	logic [15:0]          wanted_tag_q;
	logic                 out_free;
	logic                 step;
	tlvts_pkg::out_item_t res;

	assign out_free  = !out_valid_q || out_ready;
	assign step      = valid_s1 && (!item_s1.last_byte || out_free);
	assign in_ready  = !valid_s1 || step;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	tlvts_parser #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.wanted_tag(wanted_tag_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_tag_q <= '0;
		end else if (cfg_wr_en) begin
			wanted_tag_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_byte) begin
			out_item_q <= res;
		end
	end

endmodule

FILE: dv/tlv_tag_search_uint_decoder_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlv_tag_search_uint_decoder_chk
// Watches the byte and result channels and the tag register port, rebuilds
// the tag search and unsigned decode for each accepted buffer, and compares
// every result item with the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module tlv_tag_search_uint_decoder_chk #(
	parameter int unsigned MAX_BUFFER_BYTES = tlvts_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  tlvts_pkg::in_item_t  in_item,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  tlvts_pkg::out_item_t out_item,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	output int unsigned          fail_count,
	output int unsigned          pending
);

	typedef enum logic [2:0] {
		P_TAG_HI,
		P_TAG_LO,
		P_LEN_HI,
		P_LEN_LO,
		P_VALUE,
		P_DONE
	} parse_phase_t;

	localparam logic [39:0] VERSION_HDR = 40'h00_0000_0101;
	localparam int unsigned PRINT_CAP   = 40;

	logic [15:0]          search_tag;
	logic [16:0]          byte_pos;
	parse_phase_t         phase;
	bit                   hdr_good;
	logic [15:0]          tag_acc;
	logic [15:0]          len_acc;
	logic [15:0]          remaining;
	logic [63:0]          accum;
	logic [4:0]           sig_count;
	bit                   collecting;
	bit                   found;
	bit                   range_err;
	logic [16:0]          match_stop;
	tlvts_pkg::out_item_t predicted_decodes[$];
	tlvts_pkg::out_item_t oldest;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < PRINT_CAP)
			$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic clear_parse_state();
		byte_pos   = '0;
		phase      = P_TAG_HI;
		hdr_good   = 1'b1;
		tag_acc    = '0;
		len_acc    = '0;
		remaining  = '0;
		accum      = '0;
		sig_count  = '0;
		collecting = 1'b0;
		found      = 1'b0;
		range_err  = 1'b0;
		match_stop = '0;
	endtask

	task automatic parse_tlv_byte(input tlvts_pkg::in_item_t item);
		logic [16:0]          off;
		logic [7:0]           b;
		bit                   first;
		tlvts_pkg::out_item_t res;
		off = byte_pos;
		b   = item.data_byte;
		if (off < MAX_BUFFER_BYTES) begin
			if (off < tlvts_pkg::HDR_LEN && b != VERSION_HDR[39 - 8 * int'(off) -: 8])
				hdr_good = 1'b0;
			case (phase)
				P_TAG_HI: begin
					tag_acc = {b, 8'h00};
					phase   = P_TAG_LO;
				end
				P_TAG_LO: begin
					tag_acc[7:0] = b;
					phase        = P_LEN_HI;
				end
				P_LEN_HI: begin
					len_acc = {b, 8'h00};
					phase   = P_LEN_LO;
				end
				P_LEN_LO: begin
					len_acc[7:0] = b;
					if (len_acc == 16'h0000) begin
						if (tag_acc == search_tag) begin
							collecting = 1'b0;
							found      = 1'b1;
							range_err  = 1'b1;
							match_stop = off + 17'd1;
							phase      = P_DONE;
						end else begin
							phase = P_TAG_HI;
						end
					end else begin
						remaining  = len_acc;
						accum      = '0;
						sig_count  = '0;
						collecting = (tag_acc == search_tag);
						found      = 1'b0;
						range_err  = 1'b0;
						phase      = P_VALUE;
					end
				end
				P_VALUE: begin
					if (collecting) begin
						first = (remaining == len_acc);
						if (first && b[7])
							range_err = 1'b1;
						if (!(first && b == 8'h00)) begin
							if (sig_count < 5'd9)
								sig_count++;
							accum = {accum[55:0], b};
						end
					end
					remaining = remaining - 16'd1;
					if (remaining == 16'h0000) begin
						if (collecting) begin
							if (sig_count > 5'd8)
								range_err = 1'b1;
							collecting = 1'b0;
							found      = 1'b1;
							match_stop = off + 17'd1;
							phase      = P_DONE;
						end else begin
							phase = P_TAG_HI;
						end
					end
				end
				default: ;
			endcase
			byte_pos = off + 17'd1;
		end
		if (item.last_byte) begin
			res = '0;
			if (!hdr_good || byte_pos < tlvts_pkg::HDR_LEN) begin
				res.status = tlvts_pkg::ST_NOT_SUPPORTED;
			end else if (found) begin
				res.status       = range_err ? tlvts_pkg::ST_OUT_OF_RANGE : tlvts_pkg::ST_OK;
				res.value        = range_err ? 64'd0 : accum;
				res.value_length = len_acc;
				res.end_offset   = match_stop;
			end else begin
				res.status = tlvts_pkg::ST_NOT_FOUND;
			end
			predicted_decodes.push_back(res);
			clear_parse_state();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_tag = '0;
			clear_parse_state();
			predicted_decodes.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_wr_en)
				search_tag = cfg_wr_data;
			if (in_valid && in_ready)
				parse_tlv_byte(in_item);
			if (out_valid && out_ready) begin
				if (predicted_decodes.size() == 0) begin
					report_mismatch("result item with none predicted",
						64'(out_item.status), 64'd0);
				end else begin
					oldest = predicted_decodes.pop_front();
					if (out_item.status !== oldest.status)
						report_mismatch("status", 64'(out_item.status),
							64'(oldest.status));
					if (out_item.value !== oldest.value)
						report_mismatch("value", out_item.value, oldest.value);
					if (out_item.value_length !== oldest.value_length)
						report_mismatch("value_length", 64'(out_item.value_length),
							64'(oldest.value_length));
					if (out_item.end_offset !== oldest.end_offset)
						report_mismatch("end_offset", 64'(out_item.end_offset),
							64'(oldest.end_offset));
				end
			end
			pending = predicted_decodes.size();
		end
	end

endmodule

FILE: dv/tlv_tag_search_uint_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlv_tag_search_uint_decoder_tb
// Feeds byte buffers to the tag search decoder under several searched tags:
// directed header, range and truncation cases, then mostly well-formed
// random buffers with header faults and noise, with random idling on both
// channels and a long result hold-off. Checking is done by the checker
// instance beside the block.
// ----------------------------------------------------------------------------
module tlv_tag_search_uint_decoder_tb;

	localparam int unsigned CYCLE_LIMIT     = 1000000;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned RANDOM_PHASES   = 6;
	localparam int unsigned ITEMS_PER_PHASE = 90;
	localparam int unsigned DRAIN_CYCLES    = 4;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	tlvts_pkg::in_item_t  in_item;
	logic                 out_valid;
	logic                 out_ready;
	tlvts_pkg::out_item_t out_item;
	logic                 cfg_wr_en;
	logic [15:0]          cfg_wr_data;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	bit          hold_req;
	logic [15:0] search_tag;
	logic [7:0]  frame[$];

	tlv_tag_search_uint_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	tlv_tag_search_uint_decoder_chk chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic lst, input int unsigned gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= '{data_byte: b, last_byte: lst};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_frame(input bit steady);
		for (int i = 0; i < frame.size(); i++)
			put_byte(frame[i], i == frame.size() - 1, steady ? 0 : pick_gap());
		items_sent += frame.size();
		frame.delete();
	endtask

	task automatic idle_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic set_search_tag(input logic [15:0] tag);
		idle_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= tag;
		@(negedge clk);
		cfg_wr_en  <= 1'b0;
		search_tag = tag;
	endtask

	task automatic push_u16(input logic [15:0] v);
		frame.push_back(v[15:8]);
		frame.push_back(v[7:0]);
	endtask

	task automatic push_version();
		frame.push_back(8'h00);
		frame.push_back(8'h00);
		frame.push_back(8'h00);
		frame.push_back(8'h01);
		frame.push_back(8'h01);
	endtask

	task automatic push_value(input int unsigned len);
		int unsigned r;
		for (int unsigned k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			if (k == 0 && r < 30)
				frame.push_back(8'h00);
			else if (k == 0 && r < 50)
				frame.push_back(8'h80 | 8'($urandom_range(0, 127)));
			else
				frame.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic build_random_frame();
		int unsigned kind;
		int unsigned r;
		int unsigned len;
		logic [15:0] tag;
		kind = $urandom_range(0, 99);
		if (kind >= 90) begin
			repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(0, 255)));
			return;
		end
		push_version();
		repeat ($urandom_range(0, 3)) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				tag = search_tag;
			else if (r < 60)
				tag = search_tag ^ (16'h0001 << $urandom_range(0, 15));
			else
				tag = 16'($urandom_range(0, 65535));
			push_u16(tag);
			r = $urandom_range(0, 99);
			if (r < 5) begin
				push_u16(16'($urandom_range(64, 65535)));
				push_value($urandom_range(0, 6));
				break;
			end
			if (r < 15)
				len = 0;
			else if (r < 90)
				len = $urandom_range(1, 10);
			else
				len = $urandom_range(11, 40);
			push_u16(16'(len));
			push_value(len);
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) if (frame.size() > 1) void'(frame.pop_back());
		if (kind >= 80) begin
			r = $urandom_range(0, (frame.size() > 5) ? 4 : frame.size() - 1);
			frame[r] = frame[r] ^ (8'h01 << $urandom_range(0, 7));
		end
	endtask

	initial begin
		int unsigned stall_left;
		out_ready  = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		int unsigned phase_start;
		bit          pressure_done;
		in_valid      = 1'b0;
		in_item       = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		arst_n        = 1'b0;
		hold_req      = 1'b0;
		search_tag    = '0;
		pressure_done = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// searched tag still at its reset value: the header itself matches
		push_version();
		send_frame(1'b0);
		frame = '{8'h00, 8'h00, 8'h00};
		send_frame(1'b0);
		frame.push_back(8'hFF);
		send_frame(1'b0);

		set_search_tag(16'hFFFF);
		push_version();
		push_u16(16'hFFFF);
		push_u16(16'h0000);
		send_frame(1'b0);
		push_version();
		push_u16(16'hFFFF);
		push_u16(16'd9);
		frame.push_back(8'h00);
		repeat (8) frame.push_back(8'hFF);
		send_frame(1'b0);
		push_version();
		push_u16(16'hFFFF);
		push_u16(16'd2);
		frame.push_back(8'h80);
		frame.push_back(8'h00);
		send_frame(1'b0);
		push_version();
		push_u16(16'hFFFF);
		push_u16(16'd10);
		frame.push_back(8'h00);
		repeat (9) frame.push_back(8'h5A);
		send_frame(1'b0);
		frame = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
		push_u16(16'hFFFF);
		push_u16(16'd1);
		frame.push_back(8'h05);
		send_frame(1'b0);
		push_version();
		push_u16(16'hFFFF);
		frame.push_back(8'h00);
		send_frame(1'b0);
		push_version();
		push_u16(16'hFFFF);
		push_u16(16'd4);
		frame.push_back(8'h01);
		frame.push_back(8'h02);
		send_frame(1'b0);
		push_version();
		push_u16(16'h1234);
		push_u16(16'd1);
		frame.push_back(8'hAA);
		push_u16(16'hFFFF);
		push_u16(16'd1);
		frame.push_back(8'h7F);
		push_u16(16'hFFFF);
		push_u16(16'd1);
		frame.push_back(8'h01);
		frame.push_back(8'h33);
		send_frame(1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				set_search_tag(16'h0000);
			else if (p == 1)
				set_search_tag(16'hFFFF);
			else
				set_search_tag(16'($urandom_range(0, 65535)));
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				if (p == 2 && !pressure_done && items_sent - phase_start > 40) begin
					hold_req = 1'b1;
					repeat (15) begin
						repeat ($urandom_range(1, 3))
							frame.push_back(8'($urandom_range(0, 255)));
						send_frame(1'b1);
					end
					idle_until_drained();
					pressure_done = 1'b1;
				end
				build_random_frame();
				send_frame($urandom_range(0, 3) == 0);
			end
		end

		idle_until_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
